// ===== rtl/core/tpt_pkg.sv =====
// shared types, byte codes and constants for the text page position tracker
// used by tpt_step and text_page_position_tracker_unit; no dependencies

package tpt_pkg;

    localparam int COL_W  = 7;
    localparam int LINE_W = 8;
    localparam int CFG_W  = 7;
    localparam int CHAR_W = 8;

    // tab stop spacing, in columns
    localparam int TAB_STOP = 8;

    localparam logic [CFG_W-1:0] LINES_RESET   = 7'd23;
    localparam logic [CFG_W-1:0] COLUMNS_RESET = 7'd80;

    localparam logic signed [LINE_W-1:0] LINE_MAX = 8'sh7f;
    localparam logic signed [LINE_W-1:0] LINE_MIN = 8'sh80;

    // stream bytes with their own cursor handling
    localparam logic [CHAR_W-1:0] CH_BS = 8'h08;
    localparam logic [CHAR_W-1:0] CH_HT = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR = 8'h0d;

    // keys understood while paused
    localparam logic [CHAR_W-1:0] KEY_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] KEY_QUOTE   = 8'h27;
    localparam logic [CHAR_W-1:0] KEY_UPPER_N = 8'h4e;
    localparam logic [CHAR_W-1:0] KEY_UPPER_Q = 8'h51;
    localparam logic [CHAR_W-1:0] KEY_LOWER_N = 8'h6e;
    localparam logic [CHAR_W-1:0] KEY_LOWER_Q = 8'h71;

    typedef enum logic [1:0] {
        OP_CHAR    = 2'd0,
        OP_KEY     = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_LINES   = 2'd0,
        REG_COLUMNS = 2'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_NEXT_PAGE = 3'd1,
        ACT_ONE_LINE  = 3'd2,
        ACT_QUIT      = 3'd3,
        ACT_REWIND    = 3'd4,
        ACT_SKIP_FILE = 3'd5,
        ACT_IGNORED   = 3'd6
    } action_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [CHAR_W-1:0] char_code;
        logic [CHAR_W-1:0] key_code;
    } item_t;

    typedef struct packed {
        logic [COL_W-1:0]         column;
        logic signed [LINE_W-1:0] line;
        logic                     waiting;
        logic                     discarding;
    } cursor_t;

    typedef struct packed {
        logic              pass_char;
        logic [CHAR_W-1:0] char_out;
        logic              page_full;
        logic [2:0]        action;
        logic              waiting;
        logic              discarding;
    } result_t;

endpackage

// ===== rtl/core/tpt_step.sv =====
// cursor update for one item: next cursor state and the result beat
// pure combinational; depends on tpt_pkg

module tpt_step (
    input  tpt_pkg::cursor_t         cur,
    input  tpt_pkg::item_t           item,
    input  logic [tpt_pkg::CFG_W-1:0] lines_per_page,
    input  logic [tpt_pkg::CFG_W-1:0] columns_per_line,
    output tpt_pkg::cursor_t         cur_next,
    output tpt_pkg::result_t         res
);

    localparam int TAB_ENTRIES = 2 ** tpt_pkg::COL_W;

    logic [tpt_pkg::COL_W:0]          tab_lut [TAB_ENTRIES];
    logic [tpt_pkg::CFG_W-1:0]        eff_lines;
    logic [tpt_pkg::CFG_W-1:0]        eff_cols;
    logic [tpt_pkg::COL_W-1:0]        cols_m1;
    logic signed [tpt_pkg::LINE_W-1:0] line_inc;
    logic                             line_full;
    logic [tpt_pkg::COL_W:0]          col_inc;
    logic [tpt_pkg::COL_W:0]          tab_col;

    // next tab stop for every column, settled at elaboration
    for (genvar i = 0; i < TAB_ENTRIES; i++) begin : g_tab
        assign tab_lut[i] = (tpt_pkg::COL_W + 1)'((i / tpt_pkg::TAB_STOP + 1)
                                                  * tpt_pkg::TAB_STOP);
    end

    assign eff_lines = (lines_per_page == '0) ? tpt_pkg::CFG_W'(1) : lines_per_page;
    assign eff_cols  = (columns_per_line < tpt_pkg::CFG_W'(2)) ? tpt_pkg::CFG_W'(2)
                                                               : columns_per_line;
    assign cols_m1   = eff_cols - tpt_pkg::COL_W'(1);

    // line advance saturates at the top, page is full at or beyond the limit
    assign line_inc  = (cur.line != tpt_pkg::LINE_MAX) ? cur.line + 8'sd1 : cur.line;
    assign line_full = line_inc >= $signed({1'b0, eff_lines});

    assign col_inc = {1'b0, cur.column} + (tpt_pkg::COL_W + 1)'(1);
    assign tab_col = tab_lut[cur.column];

    always_comb
    begin
        cur_next      = cur;
        res           = '0;
        res.action    = tpt_pkg::ACT_NONE;
        unique case (item.operation)
            tpt_pkg::OP_CHAR:
            begin
                if (!cur.waiting && !cur.discarding)
                begin
                    res.pass_char = 1'b1;
                    res.char_out  = item.char_code;
                    unique case (item.char_code)
                        tpt_pkg::CH_LF:
                        begin
                            cur_next.column = '0;
                            if (line_full)
                            begin
                                cur_next.line    = '0;
                                cur_next.waiting = 1'b1;
                                res.page_full    = 1'b1;
                            end
                            else
                            begin
                                cur_next.line = line_inc;
                            end
                        end
                        tpt_pkg::CH_CR:
                        begin
                            cur_next.column = '0;
                        end
                        tpt_pkg::CH_BS:
                        begin
                            if (cur.column != '0)
                            begin
                                cur_next.column = cur.column - tpt_pkg::COL_W'(1);
                            end
                            else
                            begin
                                if (cur.line != tpt_pkg::LINE_MIN)
                                begin
                                    cur_next.line = cur.line - 8'sd1;
                                end
                                cur_next.column = cols_m1;
                            end
                        end
                        tpt_pkg::CH_HT:
                        begin
                            cur_next.column = (tab_col > {1'b0, cols_m1})
                                              ? cols_m1 : tab_col[tpt_pkg::COL_W-1:0];
                        end
                        default:
                        begin
                            if (col_inc >= {1'b0, eff_cols})
                            begin
                                cur_next.column = '0;
                                if (line_full)
                                begin
                                    cur_next.line    = '0;
                                    cur_next.waiting = 1'b1;
                                    res.page_full    = 1'b1;
                                end
                                else
                                begin
                                    cur_next.line = line_inc;
                                end
                            end
                            else
                            begin
                                cur_next.column = col_inc[tpt_pkg::COL_W-1:0];
                            end
                        end
                    endcase
                end
            end
            tpt_pkg::OP_KEY:
            begin
                if (!cur.waiting)
                begin
                    res.action = tpt_pkg::ACT_IGNORED;
                end
                else
                begin
                    unique case (item.key_code)
                        tpt_pkg::KEY_SPACE:
                        begin
                            cur_next.line    = '0;
                            cur_next.waiting = 1'b0;
                            res.action       = tpt_pkg::ACT_NEXT_PAGE;
                        end
                        tpt_pkg::CH_CR, tpt_pkg::CH_LF:
                        begin
                            // one more line before the next pause
                            cur_next.line    = $signed({1'b0, eff_lines - tpt_pkg::CFG_W'(1)});
                            cur_next.waiting = 1'b0;
                            res.action       = tpt_pkg::ACT_ONE_LINE;
                        end
                        tpt_pkg::KEY_LOWER_Q, tpt_pkg::KEY_UPPER_Q:
                        begin
                            cur_next.waiting    = 1'b0;
                            cur_next.discarding = 1'b1;
                            res.action          = tpt_pkg::ACT_QUIT;
                        end
                        tpt_pkg::KEY_QUOTE:
                        begin
                            cur_next.waiting    = 1'b0;
                            cur_next.discarding = 1'b1;
                            res.action          = tpt_pkg::ACT_REWIND;
                        end
                        tpt_pkg::KEY_LOWER_N, tpt_pkg::KEY_UPPER_N:
                        begin
                            cur_next.waiting    = 1'b0;
                            cur_next.discarding = 1'b1;
                            res.action          = tpt_pkg::ACT_SKIP_FILE;
                        end
                        default:
                        begin
                            res.action = tpt_pkg::ACT_IGNORED;
                        end
                    endcase
                end
            end
            tpt_pkg::OP_RESTART:
            begin
                cur_next.discarding = 1'b0;
            end
            default:
            begin
                cur_next = cur;
            end
        endcase
        res.waiting    = cur_next.waiting;
        res.discarding = cur_next.discarding;
    end

endmodule

// ===== rtl/core/text_page_position_tracker_unit.sv =====
// top level of the text page position tracker: handshake, config and state registers
// depends on tpt_pkg and tpt_step

// Takes one item per clock while in_stall is low and gives one result beat per
// item. An accepted beat lands in an input register; when the result register
// is free, the cursor update in tpt_step runs from that register into the
// result register, so each beat passes the input register and then the result register.
// The cursor state is updated in the same cycle the result is captured, which
// closes the state-to-state loop and lets items follow back to
// back. The input register keeps accepting while a finished result waits; only
// when the result register is held and the input register is full does the
// block stall its input. Register writes take effect at once and belong in
// idle periods; an out-of-range index is ignored.

module text_page_position_tracker_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [1:0]                  cfg_index,
    input  logic [tpt_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  operation,
    input  logic [tpt_pkg::CHAR_W-1:0]  char_code,
    input  logic [tpt_pkg::CHAR_W-1:0]  key_code,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        pass_char,
    output logic [tpt_pkg::CHAR_W-1:0]  char_out,
    output logic                        page_full,
    output logic [2:0]                  action,
    output logic                        waiting,
    output logic                        discarding
);

    logic [tpt_pkg::CFG_W-1:0] lines_reg;
    logic [tpt_pkg::CFG_W-1:0] columns_reg;
    logic                      in_valid_reg;
    logic                      in_valid_next;
    tpt_pkg::item_t            item_reg;
    tpt_pkg::cursor_t          cursor_reg;
    tpt_pkg::cursor_t          cursor_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    tpt_pkg::result_t          result_reg;
    tpt_pkg::result_t          result_next;
    logic                      out_free;
    logic                      fire;
    logic                      accept_in;

    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign accept_in = in_valid && !in_stall;

    assign in_valid_next  = accept_in || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && out_stall);

    tpt_step u_step (
        .cur              (cursor_reg),
        .item             (item_reg),
        .lines_per_page   (lines_reg),
        .columns_per_line (columns_reg),
        .cur_next         (cursor_next),
        .res              (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_reg   <= tpt_pkg::LINES_RESET;
            columns_reg <= tpt_pkg::COLUMNS_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                tpt_pkg::REG_LINES:   lines_reg   <= cfg_data;
                tpt_pkg::REG_COLUMNS: columns_reg <= cfg_data;
                default:
                begin
                    lines_reg <= lines_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cursor_reg    <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                cursor_reg <= cursor_next;
            end
        end
    end

    // payload beats, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            item_reg <= '{operation: operation, char_code: char_code, key_code: key_code};
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pass_char  = result_reg.pass_char;
    assign char_out   = result_reg.char_out;
    assign page_full  = result_reg.page_full;
    assign action     = result_reg.action;
    assign waiting    = result_reg.waiting;
    assign discarding = result_reg.discarding;

    // pausing and discarding exclude each other
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cursor_reg.waiting && cursor_reg.discarding))
        else $error("cursor waiting and discarding at once");

    // a page-full beat always leaves the block waiting
    a_full_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.page_full) |-> result_reg.waiting)
        else $error("page full without waiting");

    // a forwarded character never comes from a discarding block
    a_pass_not_discard: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.pass_char) |-> !result_reg.discarding)
        else $error("character passed while discarding");

    // every beat taken from the input register appears as a result
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("result beat lost");

    // cursor state moves only with a result beat
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(cursor_reg))
        else $error("cursor changed without an item");

endmodule

// ===== dv/text_page_position_tracker_unit_tb.sv =====
// self-checking testbench for text_page_position_tracker_unit: directed table, then random
// phases under several page settings; depends on tpt_pkg and the rtl top level only

module text_page_position_tracker_unit_tb;

    import tpt_pkg::*;

    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         ITEMS_PER_PHASE = 232;
    localparam int         PHASES          = 8;
    localparam int         QUIET_LIMIT     = 400;

    localparam logic [CHAR_W-1:0] PAUSE_KEYS [8] = '{
        KEY_SPACE, CH_CR, CH_LF, KEY_LOWER_Q, KEY_UPPER_Q, KEY_QUOTE, KEY_LOWER_N, KEY_UPPER_N
    };

    typedef struct {
        bit                is_write;
        cfg_idx_t          reg_idx;
        logic [CFG_W-1:0]  reg_val;
        item_t             beat;
        bit                typed;
        result_t           want;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_write_en;
    logic [1:0]          cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          operation;
    logic [CHAR_W-1:0]   char_code;
    logic [CHAR_W-1:0]   key_code;
    logic                out_valid;
    logic                out_stall;
    logic                pass_char;
    logic [CHAR_W-1:0]   char_out;
    logic                page_full;
    logic [2:0]          action;
    logic                waiting;
    logic                discarding;

    // cursor tracker state, mirrors the block
    logic [CFG_W-1:0]    page_lines = LINES_RESET;
    logic [CFG_W-1:0]    line_cols  = COLUMNS_RESET;
    int                  pos_col    = 0;
    int                  pos_line   = 0;
    bit                  pause_flag = 1'b0;
    bit                  drop_flag  = 1'b0;

    result_t             pending_results [$];
    int                  fail_count  = 0;
    int                  quiet_cycles = 0;
    int                  stall_left  = 0;
    bit                  in_idle     = 1'b1;
    bit                  out_idle    = 1'b1;
    int                  bs_left     = 0;
    bit                  deep_bs     = 1'b0;

    text_page_position_tracker_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .char_code    (char_code),
        .key_code     (key_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pass_char    (pass_char),
        .char_out     (char_out),
        .page_full    (page_full),
        .action       (action),
        .waiting      (waiting),
        .discarding   (discarding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // works out the result of one item and moves the cursor state on
    function automatic result_t track_cursor(logic [1:0] op, logic [CHAR_W-1:0] ch,
                                             logic [CHAR_W-1:0] key);
        result_t r;
        int      lines_eff;
        int      cols_eff;
        int      c;
        bit      step_line;
        r         = '0;
        step_line = 1'b0;
        lines_eff = (page_lines == 0) ? 1 : int'(page_lines);
        cols_eff  = (line_cols < 2) ? 2 : int'(line_cols);
        case (op)
            OP_CHAR:
            begin
                if (!drop_flag && !pause_flag)
                begin
                    r.pass_char = 1'b1;
                    r.char_out  = ch;
                    case (ch)
                        CH_LF:
                        begin
                            pos_col   = 0;
                            step_line = 1'b1;
                        end
                        CH_CR:
                            pos_col = 0;
                        CH_BS:
                        begin
                            if (pos_col != 0)
                                pos_col--;
                            else
                            begin
                                if (pos_line > int'(LINE_MIN))
                                    pos_line--;
                                pos_col = cols_eff - 1;
                            end
                        end
                        CH_HT:
                        begin
                            c       = pos_col + TAB_STOP - pos_col % TAB_STOP;
                            pos_col = (c > cols_eff - 1) ? cols_eff - 1 : c;
                        end
                        default:
                        begin
                            pos_col++;
                            if (pos_col >= cols_eff)
                            begin
                                pos_col   = 0;
                                step_line = 1'b1;
                            end
                        end
                    endcase
                end
            end
            OP_KEY:
            begin
                if (!pause_flag)
                    r.action = ACT_IGNORED;
                else
                begin
                    case (key)
                        KEY_SPACE:
                        begin
                            pos_line   = 0;
                            pause_flag = 1'b0;
                            r.action   = ACT_NEXT_PAGE;
                        end
                        CH_CR, CH_LF:
                        begin
                            pos_line   = lines_eff - 1;
                            pause_flag = 1'b0;
                            r.action   = ACT_ONE_LINE;
                        end
                        KEY_LOWER_Q, KEY_UPPER_Q:
                        begin
                            pause_flag = 1'b0;
                            drop_flag  = 1'b1;
                            r.action   = ACT_QUIT;
                        end
                        KEY_QUOTE:
                        begin
                            pause_flag = 1'b0;
                            drop_flag  = 1'b1;
                            r.action   = ACT_REWIND;
                        end
                        KEY_LOWER_N, KEY_UPPER_N:
                        begin
                            pause_flag = 1'b0;
                            drop_flag  = 1'b1;
                            r.action   = ACT_SKIP_FILE;
                        end
                        default:
                            r.action = ACT_IGNORED;
                    endcase
                end
            end
            OP_RESTART:
                drop_flag = 1'b0;
            default:
                ;
        endcase
        if (step_line)
        begin
            if (pos_line < int'(LINE_MAX))
                pos_line++;
            if (pos_line >= lines_eff)
            begin
                pos_line    = 0;
                pause_flag  = 1'b1;
                r.page_full = 1'b1;
            end
        end
        r.waiting    = pause_flag;
        r.discarding = drop_flag;
        return r;
    endfunction

    function automatic result_t want_res(logic p, logic [CHAR_W-1:0] c, logic f, action_t a,
                                         logic w, logic d);
        result_t r;
        r.pass_char  = p;
        r.char_out   = c;
        r.page_full  = f;
        r.action     = a;
        r.waiting    = w;
        r.discarding = d;
        return r;
    endfunction

    function automatic dir_row_t row_in(logic [1:0] op, logic [CHAR_W-1:0] ch,
                                        logic [CHAR_W-1:0] key);
        dir_row_t r;
        r.is_write       = 1'b0;
        r.reg_idx        = REG_LINES;
        r.reg_val        = '0;
        r.beat.operation = op;
        r.beat.char_code = ch;
        r.beat.key_code  = key;
        r.typed          = 1'b0;
        r.want           = '0;
        return r;
    endfunction

    function automatic dir_row_t row_chk(logic [1:0] op, logic [CHAR_W-1:0] ch,
                                         logic [CHAR_W-1:0] key, result_t want);
        dir_row_t r;
        r       = row_in(op, ch, key);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic dir_row_t row_wr(cfg_idx_t idx, logic [CFG_W-1:0] val);
        dir_row_t r;
        r          = row_in(OP_CHAR, '0, '0);
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = val;
        return r;
    endfunction

    // mostly well-formed text and key replies, some noise
    function automatic item_t pick_item();
        item_t b;
        int    roll;
        b.operation = OP_CHAR;
        b.char_code = CHAR_W'($urandom_range(0, 255));
        b.key_code  = CHAR_W'($urandom_range(0, 255));
        roll        = $urandom_range(0, 99);
        if (pause_flag)
        begin
            if (roll < 25)
            begin
                b.operation = OP_KEY;
                b.key_code  = KEY_SPACE;
            end
            else if (roll < 70)
            begin
                b.operation = OP_KEY;
                b.key_code  = PAUSE_KEYS[3'($urandom_range(0, 7))];
            end
            else if (roll < 80)
                b.operation = OP_KEY;
            else if (roll < 94)
                b.operation = OP_CHAR;
            else if (roll < 97)
                b.operation = OP_RESTART;
            else
                b.operation = OP_UNUSED;
        end
        else if (drop_flag)
        begin
            if (roll < 60)
                b.operation = OP_RESTART;
            else if (roll < 80)
                b.operation = OP_CHAR;
            else if (roll < 95)
                b.operation = OP_KEY;
            else
                b.operation = OP_UNUSED;
        end
        else
        begin
            // long run of backspaces, deep enough to pin the line at its floor
            if (deep_bs)
            begin
                bs_left = 2 * (pos_line + 140);
                deep_bs = 1'b0;
            end
            else if (bs_left == 0 && roll == 0)
                bs_left = $urandom_range(20, 300);
            if (bs_left != 0)
            begin
                bs_left--;
                b.char_code = CH_BS;
            end
            else if (roll < 86)
            begin
                case ($urandom_range(0, 19))
                    0, 1:    b.char_code = CH_LF;
                    2:       b.char_code = CH_CR;
                    3, 4:    b.char_code = CH_BS;
                    5, 6:    b.char_code = CH_HT;
                    7, 8, 9: ;
                    default: b.char_code = CHAR_W'($urandom_range(8'h20, 8'h7e));
                endcase
            end
            else if (roll < 92)
                b.operation = OP_KEY;
            else if (roll < 96)
                b.operation = OP_RESTART;
            else
                b.operation = OP_UNUSED;
        end
        return b;
    endfunction

    task automatic drive_item(input item_t beat, input bit typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = in_idle ? $urandom_range(0, 9) : 0;
        if ($urandom_range(0, 39) == 0)
            in_idle = !in_idle;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= beat.operation;
        char_code <= beat.char_code;
        key_code  <= beat.key_code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = track_cursor(beat.operation, beat.char_code, beat.key_code);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // stop feeding and let every outstanding result come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_LINES)
            page_lines = val;
        else
            line_cols = val;
        @(posedge clk);
    endtask

    initial
    begin
        dir_row_t         directed_rows [$];
        logic [CFG_W-1:0] lines_pick [PHASES];
        logic [CFG_W-1:0] cols_pick [PHASES];
        item_t            beat;
        int               sent;
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = REG_LINES;
        cfg_data     = '0;
        in_valid     = 1'b0;
        operation    = OP_CHAR;
        char_code    = '0;
        key_code     = '0;
        out_stall    = 1'b0;

        directed_rows = '{
            row_chk(OP_CHAR, 8'h41, 8'hff, want_res(1'b1, 8'h41, 1'b0, ACT_NONE, 1'b0, 1'b0)),
            row_chk(OP_CHAR, CH_LF, 8'h00, want_res(1'b1, CH_LF, 1'b0, ACT_NONE, 1'b0, 1'b0)),
            row_chk(OP_CHAR, 8'hff, 8'h00, want_res(1'b1, 8'hff, 1'b0, ACT_NONE, 1'b0, 1'b0)),
            row_chk(OP_CHAR, CH_CR, 8'hff, want_res(1'b1, CH_CR, 1'b0, ACT_NONE, 1'b0, 1'b0)),
            row_chk(OP_CHAR, 8'h00, 8'hff, want_res(1'b1, 8'h00, 1'b0, ACT_NONE, 1'b0, 1'b0)),
            row_chk(OP_CHAR, CH_BS, 8'h00, want_res(1'b1, CH_BS, 1'b0, ACT_NONE, 1'b0, 1'b0)),
            row_chk(OP_CHAR, CH_HT, 8'h00, want_res(1'b1, CH_HT, 1'b0, ACT_NONE, 1'b0, 1'b0)),
            row_chk(OP_KEY, 8'h41, KEY_SPACE,
                    want_res(1'b0, 8'h00, 1'b0, ACT_IGNORED, 1'b0, 1'b0)),
            row_chk(OP_RESTART, 8'hff, 8'hff,
                    want_res(1'b0, 8'h00, 1'b0, ACT_NONE, 1'b0, 1'b0)),
            row_chk(OP_UNUSED, 8'hff, 8'hff,
                    want_res(1'b0, 8'h00, 1'b0, ACT_NONE, 1'b0, 1'b0)),
            // zero lines and one column are taken as one line and two columns
            row_wr(REG_LINES, 7'd0),
            row_wr(REG_COLUMNS, 7'd1),
            // column already past the new width wraps at once and fills the page
            row_chk(OP_CHAR, 8'h78, 8'h00, want_res(1'b1, 8'h78, 1'b1, ACT_NONE, 1'b1, 1'b0)),
            row_chk(OP_CHAR, 8'h7a, 8'h00, want_res(1'b0, 8'h00, 1'b0, ACT_NONE, 1'b1, 1'b0)),
            row_chk(OP_KEY, 8'h00, 8'h61,
                    want_res(1'b0, 8'h00, 1'b0, ACT_IGNORED, 1'b1, 1'b0)),
            row_chk(OP_KEY, 8'h00, KEY_SPACE,
                    want_res(1'b0, 8'h00, 1'b0, ACT_NEXT_PAGE, 1'b0, 1'b0)),
            // backspace at column 0 drops to the previous line
            row_chk(OP_CHAR, CH_BS, 8'h00, want_res(1'b1, CH_BS, 1'b0, ACT_NONE, 1'b0, 1'b0)),
            row_chk(OP_CHAR, CH_LF, 8'h00, want_res(1'b1, CH_LF, 1'b0, ACT_NONE, 1'b0, 1'b0)),
            row_chk(OP_CHAR, CH_LF, 8'h00, want_res(1'b1, CH_LF, 1'b1, ACT_NONE, 1'b1, 1'b0)),
            row_chk(OP_KEY, 8'h00, CH_CR,
                    want_res(1'b0, 8'h00, 1'b0, ACT_ONE_LINE, 1'b0, 1'b0)),
            row_in(OP_CHAR, CH_LF, 8'h00),
            row_chk(OP_KEY, 8'h00, KEY_LOWER_Q,
                    want_res(1'b0, 8'h00, 1'b0, ACT_QUIT, 1'b0, 1'b1)),
            row_chk(OP_CHAR, 8'h6b, 8'h00, want_res(1'b0, 8'h00, 1'b0, ACT_NONE, 1'b0, 1'b1)),
            row_chk(OP_RESTART, 8'h00, 8'h00,
                    want_res(1'b0, 8'h00, 1'b0, ACT_NONE, 1'b0, 1'b0)),
            row_in(OP_CHAR, CH_LF, 8'h00),
            row_chk(OP_KEY, 8'h00, KEY_QUOTE,
                    want_res(1'b0, 8'h00, 1'b0, ACT_REWIND, 1'b0, 1'b1)),
            row_in(OP_RESTART, 8'h00, 8'h00),
            row_in(OP_CHAR, CH_LF, 8'h00),
            row_chk(OP_KEY, 8'h00, KEY_LOWER_N,
                    want_res(1'b0, 8'h00, 1'b0, ACT_SKIP_FILE, 1'b0, 1'b1)),
            row_in(OP_RESTART, 8'h00, 8'h00)
        };

        lines_pick = '{7'd1, 7'd100, 7'd127, 7'd127, 7'd0, 7'd0, 7'd0, 7'd5};
        cols_pick  = '{7'd1, 7'd2, 7'd127, 7'd2, 7'd0, 7'd0, 7'd0, 7'd3};
        lines_pick[5] = CFG_W'($urandom_range(0, 127));
        lines_pick[6] = CFG_W'($urandom_range(0, 127));
        cols_pick[5]  = CFG_W'($urandom_range(0, 127));
        cols_pick[6]  = CFG_W'($urandom_range(0, 127));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                drain();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
                drive_item(directed_rows[i].beat, directed_rows[i].typed,
                           directed_rows[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            write_reg(REG_LINES, lines_pick[ph]);
            write_reg(REG_COLUMNS, cols_pick[ph]);
            deep_bs = (ph == 1);
            sent    = 0;
            // only the deep backspace phase runs on past its share
            while (sent < ITEMS_PER_PHASE || deep_bs || (ph == 1 && bs_left != 0))
            begin
                beat = pick_item();
                drive_item(beat, 1'b0, '0);
                if (beat.operation != OP_UNUSED)
                    sent++;
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // result checking and receiver back-pressure
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing pending");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (pass_char !== want.pass_char)
                begin
                    $error("pass_char: expected %0d, got %0d", want.pass_char, pass_char);
                    fail_count++;
                end
                if (char_out !== want.char_out)
                begin
                    $error("char_out: expected %0h, got %0h", want.char_out, char_out);
                    fail_count++;
                end
                if (page_full !== want.page_full)
                begin
                    $error("page_full: expected %0d, got %0d", want.page_full, page_full);
                    fail_count++;
                end
                if (action !== want.action)
                begin
                    $error("action: expected %0d, got %0d", want.action, action);
                    fail_count++;
                end
                if (waiting !== want.waiting)
                begin
                    $error("waiting: expected %0d, got %0d", want.waiting, waiting);
                    fail_count++;
                end
                if (discarding !== want.discarding)
                begin
                    $error("discarding: expected %0d, got %0d", want.discarding, discarding);
                    fail_count++;
                end
            end
            stall_left = out_idle ? $urandom_range(0, 9) : 0;
            if ($urandom_range(0, 39) == 0)
                out_idle = !out_idle;
        end
        else if (stall_left != 0)
            stall_left--;
        out_stall <= (stall_left != 0);
    end

    // no beat on either side for too long means the block has hung
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles++;
    end

endmodule
